@@ src/dpkp_pkg.sv @@
package dpkp_pkg;

	localparam logic [7:0] TAG_SEQUENCE = 8'h30;
	localparam logic [7:0] TAG_INTEGER  = 8'h02;
	localparam logic [7:0] TAG_BITSTR   = 8'h03;
	localparam logic [7:0] LEN_LONG     = 8'h80;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_TAG   = 3'd1;
	localparam logic [2:0] ST_LEN   = 3'd2;
	localparam logic [2:0] ST_SIZE  = 3'd3;
	localparam logic [2:0] ST_WIDE  = 3'd4;
	localparam logic [2:0] ST_TRUNC = 3'd5;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       last;
	} in_t;

	typedef struct packed {
		logic       kind;
		logic       coordinate;
		logic [4:0] position;
		logic [7:0] value;
		logic [2:0] status;
		logic       end_of_run;
	} res_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_DIRECT,
		EM_PAD,
		EM_DATA,
		EM_VERD
	} emit_t;

	typedef struct packed {
		logic  accept;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic multi;
		logic first_pad;
		logic pad_last;
		logic plan_data;
		logic plan_verd;
	} sts_t;

endpackage

@@ src/der_point_key_parser.sv @@
// A byte that gives at most one result is taken when the output register is free and its
// result sits in it on the next cycle: one byte per cycle while res_stall stays low.
// A byte that gives N > 1 results stalls the input, once it is taken, while the
// controller steps its results out through the output register, one per unstalled cycle.
// The asynchronous reset clears the parser to await a sequence tag with no failure and
// empties the output register; the byte marked last returns the parser to that state.
module der_point_key_parser
	import dpkp_pkg::*;
#(
	parameter int FIELD_BYTES = 28
)
(
	input  logic clk,
	input  logic arst_n,
	input  logic key_valid,
	output logic key_stall,
	input  in_t  key_word,
	output logic res_valid,
	input  logic res_stall,
	output res_t res_word
);

	cmd_t cmd;
	sts_t sts;

	dpkp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_stall (key_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	dpkp_datapath #(
		.FIELD_BYTES (FIELD_BYTES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_word  (key_word),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

endmodule

@@ src/dpkp_ctrl.sv @@
module dpkp_ctrl
	import dpkp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic key_valid,
	output logic key_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PAD,
		S_DATA,
		S_VERD
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt  = state_q;
		cmd.accept = 1'b0;
		cmd.emit   = EM_NONE;
		key_stall  = 1'b1;
		case (state_q)
			S_IDLE: begin
				key_stall = !sts.out_free;
				if (key_valid && sts.out_free) begin
					cmd.accept = 1'b1;
					if (!sts.multi) begin
						cmd.emit = EM_DIRECT;
					end else begin
						state_nxt = sts.first_pad ? S_PAD : S_DATA;
					end
				end
			end
			S_PAD: begin
				if (sts.out_free) begin
					cmd.emit = EM_PAD;
					if (sts.pad_last) begin
						state_nxt = sts.plan_data ? S_DATA : (sts.plan_verd ? S_VERD : S_IDLE);
					end
				end
			end
			S_DATA: begin
				if (sts.out_free) begin
					cmd.emit  = EM_DATA;
					state_nxt = sts.plan_verd ? S_VERD : S_IDLE;
				end
			end
			S_VERD: begin
				if (sts.out_free) begin
					cmd.emit  = EM_VERD;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> state_q == S_IDLE)
		else $error("item accepted outside idle");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit != EM_NONE |-> sts.out_free)
		else $error("result written over a held word");
	a_multi_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && sts.multi |=> state_q != S_IDLE)
		else $error("multi-result byte did not start emission");
`endif

endmodule

@@ src/dpkp_datapath.sv @@
module dpkp_datapath
	import dpkp_pkg::*;
#(
	parameter int FIELD_BYTES = 28
)
(
	input  logic clk,
	input  logic arst_n,
	input  in_t  key_word,
	input  cmd_t cmd,
	output sts_t sts,
	output logic res_valid,
	input  logic res_stall,
	output res_t res_word
);

	localparam int PW = $clog2(FIELD_BYTES + 1);

	typedef enum logic [4:0] {
		PH_SEQ_TAG,
		PH_SEQ_LEN,
		PH_BIT_TAG,
		PH_BIT_LEN,
		PH_BIT_BODY,
		PH_SIZE_TAG,
		PH_SIZE_LEN,
		PH_SIZE_VAL,
		PH_X_TAG,
		PH_X_LEN,
		PH_X_FIRST,
		PH_X_BODY,
		PH_Y_TAG,
		PH_Y_LEN,
		PH_Y_FIRST,
		PH_Y_BODY,
		PH_DONE
	} phase_t;

	phase_t        phase_q;
	logic [7:0]    seen_q;
	logic [7:0]    needed_q;
	logic [6:0]    left_q;
	logic [2:0]    fail_q;

	phase_t        nxt_phase;
	logic [7:0]    nxt_seen;
	logic [7:0]    nxt_needed;
	logic [6:0]    nxt_left;
	logic [2:0]    nxt_fail;

	logic [7:0]    b;
	logic          len_ok;
	logic [8:0]    end_sum;
	logic [7:0]    end_sat;
	logic [7:0]    len_needed;
	logic [6:0]    left_dec;
	logic [6:0]    count;
	logic [PW-1:0] pad_n;
	logic          has_data;
	logic [PW-1:0] data_pos;
	logic          coord;
	logic          has_verd;
	logic [2:0]    verd_status;

	logic          coord_q;
	logic [PW-1:0] pad_n_q;
	logic [PW-1:0] pos_q;
	logic          has_data_q;
	logic [PW-1:0] data_pos_q;
	logic [7:0]    data_q;
	logic          has_verd_q;
	logic [2:0]    status_q;

	logic          out_valid_q;
	res_t          out_q;
	res_t          direct_res;
	res_t          seq_res;

	assign b          = key_word.byte_in;
	assign len_ok     = b < LEN_LONG;
	assign end_sum    = {1'b0, nxt_seen} + {1'b0, b};
	assign end_sat    = end_sum[8] ? 8'hFF : end_sum[7:0];
	assign len_needed = (end_sat > needed_q) ? end_sat : needed_q;
	assign left_dec   = left_q - 7'd1;
	assign count      = left_q - {6'd0, (b == 8'd0)};

	always_comb begin
		nxt_phase   = phase_q;
		nxt_seen    = (seen_q == 8'hFF) ? seen_q : seen_q + 8'd1;
		nxt_needed  = needed_q;
		nxt_left    = left_q;
		nxt_fail    = fail_q;
		pad_n       = '0;
		has_data    = 1'b0;
		data_pos    = '0;
		coord       = 1'b0;
		if (fail_q == ST_OK) begin
			case (phase_q)
				PH_SEQ_TAG: begin
					if (b != TAG_SEQUENCE) nxt_fail = ST_TAG;
					else nxt_phase = PH_SEQ_LEN;
				end
				PH_BIT_TAG: begin
					if (b != TAG_BITSTR) nxt_fail = ST_TAG;
					else nxt_phase = PH_BIT_LEN;
				end
				PH_SIZE_TAG: begin
					if (b != TAG_INTEGER) nxt_fail = ST_TAG;
					else nxt_phase = PH_SIZE_LEN;
				end
				PH_X_TAG: begin
					if (b != TAG_INTEGER) nxt_fail = ST_TAG;
					else nxt_phase = PH_X_LEN;
				end
				PH_Y_TAG: begin
					if (b != TAG_INTEGER) nxt_fail = ST_TAG;
					else nxt_phase = PH_Y_LEN;
				end
				PH_SEQ_LEN: begin
					if (!len_ok) begin
						nxt_fail = ST_LEN;
					end else begin
						nxt_needed = len_needed;
						nxt_left   = b[6:0];
						nxt_phase  = PH_BIT_TAG;
					end
				end
				PH_BIT_LEN: begin
					if (!len_ok) begin
						nxt_fail = ST_LEN;
					end else begin
						nxt_needed = len_needed;
						nxt_left   = b[6:0];
						nxt_phase  = (b[6:0] != 7'd0) ? PH_BIT_BODY : PH_SIZE_TAG;
					end
				end
				PH_BIT_BODY: begin
					nxt_left = left_dec;
					if (left_dec == 7'd0) nxt_phase = PH_SIZE_TAG;
				end
				PH_SIZE_LEN: begin
					if (!len_ok) begin
						nxt_fail = ST_LEN;
					end else begin
						nxt_needed = len_needed;
						nxt_left   = b[6:0];
						if (b != 8'd1) nxt_fail = ST_SIZE;
						else nxt_phase = PH_SIZE_VAL;
					end
				end
				PH_SIZE_VAL: begin
					if (b != 8'(FIELD_BYTES)) nxt_fail = ST_SIZE;
					else nxt_phase = PH_X_TAG;
				end
				PH_X_LEN, PH_Y_LEN: begin
					if (!len_ok) begin
						nxt_fail = ST_LEN;
					end else begin
						nxt_needed = len_needed;
						nxt_left   = b[6:0];
						if (b == 8'd0) nxt_fail = ST_LEN;
						else nxt_phase = (phase_q == PH_X_LEN) ? PH_X_FIRST : PH_Y_FIRST;
					end
				end
				PH_X_FIRST, PH_Y_FIRST: begin
					coord = (phase_q == PH_Y_FIRST);
					if (count > 7'(FIELD_BYTES)) begin
						nxt_fail = ST_WIDE;
					end else begin
						pad_n    = PW'(7'(FIELD_BYTES) - count);
						has_data = (b != 8'd0);
						data_pos = pad_n;
						nxt_left = left_dec;
						if (left_dec != 7'd0) nxt_phase = coord ? PH_Y_BODY : PH_X_BODY;
						else nxt_phase = coord ? PH_DONE : PH_Y_TAG;
					end
				end
				PH_X_BODY, PH_Y_BODY: begin
					coord    = (phase_q == PH_Y_BODY);
					has_data = 1'b1;
					data_pos = PW'(7'(FIELD_BYTES) - left_q);
					nxt_left = left_dec;
					if (left_dec == 7'd0) nxt_phase = coord ? PH_DONE : PH_Y_TAG;
				end
				default: begin
				end
			endcase
		end
		has_verd    = key_word.last;
		verd_status = nxt_fail;
		if (nxt_fail == ST_OK && (nxt_phase != PH_DONE || nxt_needed > nxt_seen)) begin
			verd_status = ST_TRUNC;
		end
		if (key_word.last) begin
			nxt_phase  = PH_SEQ_TAG;
			nxt_seen   = 8'd0;
			nxt_needed = 8'd0;
			nxt_left   = 7'd0;
			nxt_fail   = ST_OK;
		end
	end

	always_comb begin
		direct_res            = '0;
		direct_res.end_of_run = 1'b1;
		if (pad_n != '0) begin
			direct_res.coordinate = coord;
		end else if (has_data) begin
			direct_res.coordinate = coord;
			direct_res.position   = 5'(data_pos);
			direct_res.value      = b;
		end else begin
			direct_res.kind   = 1'b1;
			direct_res.status = verd_status;
		end
	end

	assign sts.out_free  = !out_valid_q || !res_stall;
	assign sts.multi     = ((pad_n != '0) && ((pad_n != PW'(1)) || has_data || has_verd))
	                       || (has_data && has_verd);
	assign sts.first_pad = (pad_n != '0);
	assign sts.pad_last  = (pos_q == pad_n_q - PW'(1));
	assign sts.plan_data = has_data_q;
	assign sts.plan_verd = has_verd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEQ_TAG;
			seen_q   <= 8'd0;
			needed_q <= 8'd0;
			left_q   <= 7'd0;
			fail_q   <= ST_OK;
		end else if (cmd.accept) begin
			phase_q  <= nxt_phase;
			seen_q   <= nxt_seen;
			needed_q <= nxt_needed;
			left_q   <= nxt_left;
			fail_q   <= nxt_fail;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			coord_q    <= coord;
			pad_n_q    <= pad_n;
			pos_q      <= '0;
			has_data_q <= has_data;
			data_pos_q <= data_pos;
			data_q     <= b;
			has_verd_q <= has_verd;
			status_q   <= verd_status;
		end else if (cmd.emit == EM_PAD) begin
			pos_q <= pos_q + PW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit == EM_DIRECT) begin
			out_valid_q <= (pad_n != '0) || has_data || has_verd;
		end else if (cmd.emit != EM_NONE) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		seq_res = '0;
		case (cmd.emit)
			EM_DIRECT: begin
				seq_res = direct_res;
			end
			EM_PAD: begin
				seq_res.coordinate = coord_q;
				seq_res.position   = 5'(pos_q);
				seq_res.end_of_run = (pos_q == pad_n_q - PW'(1)) && !has_data_q && !has_verd_q;
			end
			EM_DATA: begin
				seq_res.coordinate = coord_q;
				seq_res.position   = 5'(data_pos_q);
				seq_res.value      = data_q;
				seq_res.end_of_run = !has_verd_q;
			end
			EM_VERD: begin
				seq_res.kind       = 1'b1;
				seq_res.status     = status_q;
				seq_res.end_of_run = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != EM_NONE) begin
			out_q <= seq_res;
		end
	end

	assign res_valid = out_valid_q;
	assign res_word  = out_q;

`ifndef NO_ASSERTIONS
	a_verdict_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind |-> out_q.end_of_run)
		else $error("verdict without end of run");
	a_pad_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit == EM_PAD |-> pos_q < pad_n_q)
		else $error("padding position past its run");
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && key_word.last |=> phase_q == PH_SEQ_TAG && fail_q == ST_OK)
		else $error("parser not restarted after last byte");
`endif

endmodule

@@ dv/tb.sv @@
module tb;
	import dpkp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FIELD_BYTES = 28;
	localparam int LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_BYTES = 145;

	typedef enum logic [4:0] {
		P_SEQ_TAG, P_SEQ_LEN, P_BIT_TAG, P_BIT_LEN, P_BIT_BODY,
		P_SIZE_TAG, P_SIZE_LEN, P_SIZE_VAL, P_X_TAG, P_X_LEN, P_X_FIRST, P_X_BODY,
		P_Y_TAG, P_Y_LEN, P_Y_FIRST, P_Y_BODY, P_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       typed;
		logic [2:0] status;
	} dir_row_t;

	localparam int DIR_ROWS = 22;
	localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
		'{8'hFF, 1'b1, 1'b1, ST_TAG},
		'{TAG_SEQUENCE, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b1, 1'b1, ST_LEN},
		'{TAG_SEQUENCE, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{TAG_BITSTR, 1'b0, 1'b0, ST_OK},
		'{8'h01, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{TAG_INTEGER, 1'b0, 1'b0, ST_OK},
		'{8'h02, 1'b1, 1'b1, ST_SIZE},
		'{TAG_SEQUENCE, 1'b0, 1'b0, ST_OK},
		'{8'h7F, 1'b0, 1'b0, ST_OK},
		'{TAG_BITSTR, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{TAG_INTEGER, 1'b0, 1'b0, ST_OK},
		'{8'h01, 1'b0, 1'b0, ST_OK},
		'{8'h1C, 1'b0, 1'b0, ST_OK},
		'{TAG_INTEGER, 1'b0, 1'b0, ST_OK},
		'{8'h1E, 1'b0, 1'b0, ST_OK},
		'{8'h01, 1'b0, 1'b0, ST_OK},
		'{8'h55, 1'b1, 1'b1, ST_WIDE},
		'{TAG_SEQUENCE, 1'b1, 1'b1, ST_TRUNC}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic key_valid = 1'b0;
	logic key_stall;
	in_t  key_word = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_word;

	der_point_key_parser #(.FIELD_BYTES(FIELD_BYTES)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_stall (key_stall),
		.key_word  (key_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	phase_t     ph_now = P_SEQ_TAG;
	int         seen_cnt = 0;
	int         need_end = 0;
	int         left_cnt = 0;
	logic [2:0] fail_st = ST_OK;

	res_t parsed_q[$];
	res_t held_r;
	bit   held_on;

	bit         typed_on = 1'b0;
	logic [2:0] typed_st = ST_OK;

	logic [7:0] key_bytes[$];

	int snd_idle = 0;
	int rcv_idle = 0;
	int hold_asked = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int cycle_cnt = 0;
	int bad_words = 0;
	int bytes_sent = 0;
	int live_cnt = 0;
	int key_cnt = 0;
	int coord_cnt = 0;
	int verdicts [0:5] = '{default: 0};

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void clear_parser();
		ph_now = P_SEQ_TAG;
		seen_cnt = 0;
		need_end = 0;
		left_cnt = 0;
		fail_st = ST_OK;
	endfunction

	function automatic void flag(input logic [2:0] code);
		if (fail_st == ST_OK) begin
			fail_st = code;
		end
	endfunction

	function automatic bit take_len(input logic [7:0] b);
		int e;
		if (b >= LEN_LONG) begin
			flag(ST_LEN);
			return 1'b0;
		end
		e = seen_cnt + int'(b);
		if (e > 255) begin
			e = 255;
		end
		if (e > need_end) begin
			need_end = e;
		end
		left_cnt = int'(b);
		return 1'b1;
	endfunction

	function automatic void emit(input res_t r);
		if (held_on) begin
			parsed_q = {parsed_q, held_r};
		end
		held_r = r;
		held_on = 1'b1;
	endfunction

	function automatic void emit_coord(input bit crd, input int pos, input logic [7:0] v);
		res_t r;
		r = '0;
		r.coordinate = crd;
		r.position = pos[4:0];
		r.value = v;
		emit(r);
	endfunction

	function automatic void expect_tag(input logic [7:0] b, input logic [7:0] tag,
			input phase_t nxt);
		if (b != tag) begin
			flag(ST_TAG);
		end else begin
			ph_now = nxt;
		end
	endfunction

	// Works out every result that one accepted word causes and queues them in order.
	function automatic void parse_key_byte(input in_t w);
		logic [7:0] b;
		bit         crd;
		int         cnt;
		int         pad;
		res_t       r;
		b = w.byte_in;
		held_on = 1'b0;
		if (fail_st == ST_OK && ph_now != P_DONE) begin
			live_cnt++;
		end
		if (seen_cnt < 255) begin
			seen_cnt++;
		end
		if (fail_st == ST_OK) begin
			case (ph_now)
				P_SEQ_TAG:  expect_tag(b, TAG_SEQUENCE, P_SEQ_LEN);
				P_BIT_TAG:  expect_tag(b, TAG_BITSTR, P_BIT_LEN);
				P_SIZE_TAG: expect_tag(b, TAG_INTEGER, P_SIZE_LEN);
				P_X_TAG:    expect_tag(b, TAG_INTEGER, P_X_LEN);
				P_Y_TAG:    expect_tag(b, TAG_INTEGER, P_Y_LEN);
				P_SEQ_LEN: begin
					if (take_len(b)) begin
						ph_now = P_BIT_TAG;
					end
				end
				P_BIT_LEN: begin
					if (take_len(b)) begin
						ph_now = (left_cnt != 0) ? P_BIT_BODY : P_SIZE_TAG;
					end
				end
				P_BIT_BODY: begin
					left_cnt--;
					if (left_cnt == 0) begin
						ph_now = P_SIZE_TAG;
					end
				end
				P_SIZE_LEN: begin
					if (take_len(b)) begin
						if (b != 8'd1) begin
							flag(ST_SIZE);
						end else begin
							ph_now = P_SIZE_VAL;
						end
					end
				end
				P_SIZE_VAL: begin
					if (int'(b) != FIELD_BYTES) begin
						flag(ST_SIZE);
					end else begin
						ph_now = P_X_TAG;
					end
				end
				P_X_LEN, P_Y_LEN: begin
					if (take_len(b)) begin
						if (b == 8'd0) begin
							flag(ST_LEN);
						end else begin
							ph_now = (ph_now == P_X_LEN) ? P_X_FIRST : P_Y_FIRST;
						end
					end
				end
				P_X_FIRST, P_Y_FIRST: begin
					crd = (ph_now == P_Y_FIRST);
					cnt = left_cnt - ((b == 8'd0) ? 1 : 0);
					if (cnt > FIELD_BYTES) begin
						flag(ST_WIDE);
					end else begin
						pad = FIELD_BYTES - cnt;
						for (int i = 0; i < pad; i++) begin
							emit_coord(crd, i, 8'd0);
						end
						if (b != 8'd0) begin
							emit_coord(crd, pad, b);
						end
						left_cnt--;
						if (left_cnt != 0) begin
							ph_now = crd ? P_Y_BODY : P_X_BODY;
						end else begin
							ph_now = crd ? P_DONE : P_Y_TAG;
						end
					end
				end
				P_X_BODY, P_Y_BODY: begin
					crd = (ph_now == P_Y_BODY);
					emit_coord(crd, FIELD_BYTES - left_cnt, b);
					left_cnt--;
					if (left_cnt == 0) begin
						ph_now = crd ? P_DONE : P_Y_TAG;
					end
				end
				default: ;
			endcase
		end
		if (w.last) begin
			r = '0;
			r.kind = 1'b1;
			r.status = fail_st;
			if (fail_st == ST_OK && (ph_now != P_DONE || need_end > seen_cnt)) begin
				r.status = ST_TRUNC;
			end
			if (typed_on) begin
				r.status = typed_st;
			end
			emit(r);
			clear_parser();
		end
		if (held_on) begin
			held_r.end_of_run = 1'b1;
			parsed_q = {parsed_q, held_r};
		end
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (key_valid && !key_stall) begin
			parse_key_byte(key_word);
		end
		if (res_valid && !res_stall) begin
			if (res_word.kind) begin
				if (res_word.status <= ST_TRUNC) begin
					verdicts[res_word.status]++;
				end
			end else begin
				coord_cnt++;
			end
			if (parsed_q.size() == 0) begin
				bad_words++;
				if (bad_words <= 10) begin
					$display("extra word: kind=%0d crd=%0d pos=%0d val=%02h st=%0d end=%0d",
						res_word.kind, res_word.coordinate, res_word.position,
						res_word.value, res_word.status, res_word.end_of_run);
				end
			end else begin
				want = parsed_q.pop_front();
				if (res_word.kind !== want.kind || res_word.coordinate !== want.coordinate ||
						res_word.position !== want.position || res_word.value !== want.value ||
						res_word.status !== want.status ||
						res_word.end_of_run !== want.end_of_run) begin
					bad_words++;
					if (bad_words <= 10) begin
						$display("cycle %0d want kind=%0d crd=%0d pos=%0d val=%02h st=%0d end=%0d",
							cycle_cnt, want.kind, want.coordinate, want.position,
							want.value, want.status, want.end_of_run);
						$display("    got kind=%0d crd=%0d pos=%0d val=%02h st=%0d end=%0d",
							res_word.kind, res_word.coordinate, res_word.position,
							res_word.value, res_word.status, res_word.end_of_run);
					end
				end
			end
		end
	end

	// A requested hold stalls the result side until its countdown here runs out; else stalls are random.
	always @(negedge clk) begin
		if (hold_seen != hold_asked) begin
			hold_seen = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < rcv_idle);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == LIMIT) begin
			$display("Timed out after %0d cycles with %0d words outstanding.",
				cycle_cnt, parsed_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_word(input in_t w);
		while ($urandom_range(99) < snd_idle) begin
			key_valid <= 1'b0;
			@(negedge clk);
		end
		key_valid <= 1'b1;
		key_word <= w;
		@(posedge clk);
		while (key_stall) begin
			@(posedge clk);
		end
		bytes_sent++;
		@(negedge clk);
	endtask

	function automatic int coord_len();
		int r;
		r = $urandom_range(9);
		if (r < 6) begin
			return $urandom_range(1, 4);
		end else if (r < 8) begin
			return $urandom_range(5, 27);
		end
		return FIELD_BYTES;
	endfunction

	function automatic void add_byte(input logic [7:0] v);
		key_bytes = {key_bytes, v};
	endfunction

	function automatic void add_integer(input int k, input bit lead_zero, input bit zero_len,
			input bit nonzero_top);
		logic [7:0] v;
		add_byte(TAG_INTEGER);
		if (zero_len) begin
			add_byte(8'd0);
			return;
		end
		add_byte(8'(k + int'(lead_zero)));
		if (lead_zero) begin
			add_byte(8'd0);
		end
		for (int i = 0; i < k; i++) begin
			v = 8'($urandom_range(255));
			if (i == 0 && nonzero_top) begin
				v = 8'($urandom_range(1, 255));
			end
			add_byte(v);
		end
	endfunction

	// Most keys are well formed with random content; the rest are noise, cut short,
	// corrupted, or carry a bad field size, an empty or an oversized coordinate.
	function automatic void build_key();
		int mode;
		int bl;
		int xk;
		int yk;
		int total;
		int r;
		int cut;
		bit xz;
		bit yz;
		bit on_y;
		key_bytes.delete();
		mode = $urandom_range(99);
		if (mode < 8) begin
			repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(255)));
			return;
		end
		bl = $urandom_range(0, 4);
		xk = coord_len();
		yk = coord_len();
		xz = ($urandom_range(2) == 0);
		yz = ($urandom_range(2) == 0);
		on_y = $urandom_range(1);
		if (mode >= 28 && mode < 34) begin
			if (on_y) begin
				yk = $urandom_range(FIELD_BYTES + 1, FIELD_BYTES + 6);
				yz = 1'b0;
			end else begin
				xk = $urandom_range(FIELD_BYTES + 1, FIELD_BYTES + 6);
				xz = 1'b0;
			end
		end
		add_byte(TAG_SEQUENCE);
		add_byte(8'd0);
		add_byte(TAG_BITSTR);
		add_byte(8'(bl));
		repeat (bl) add_byte(8'($urandom_range(255)));
		add_byte(TAG_INTEGER);
		add_byte(8'd1);
		if (mode >= 20 && mode < 24) begin
			add_byte(8'($urandom_range(255)));
		end else begin
			add_byte(8'(FIELD_BYTES));
		end
		add_integer(xk, xz, mode >= 24 && mode < 28 && !on_y, mode >= 28 && mode < 34);
		add_integer(yk, yz, mode >= 24 && mode < 28 && on_y, mode >= 28 && mode < 34);
		total = key_bytes.size() - 2;
		r = $urandom_range(7);
		if (r == 0) begin
			key_bytes[1] = 8'(total + $urandom_range(1, 5));
		end else if (r == 1) begin
			key_bytes[1] = 8'($urandom_range(0, total));
		end else begin
			key_bytes[1] = 8'(total);
		end
		repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(255)));
		if (mode >= 8 && mode < 14) begin
			cut = $urandom_range(1, key_bytes.size() - 1);
			while (key_bytes.size() > cut) begin
				void'(key_bytes.pop_back());
			end
		end else if (mode >= 14 && mode < 20) begin
			key_bytes[$urandom_range(0, key_bytes.size() - 1)] = 8'($urandom_range(255));
		end
	endfunction

	initial begin
		in_t w;
		int  start_sent;
		snd_idle = 27;
		rcv_idle = 60;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			w.byte_in = DIR_TAB[i].data;
			w.last = DIR_TAB[i].last;
			typed_on = DIR_TAB[i].typed;
			typed_st = DIR_TAB[i].status;
			send_word(w);
		end
		typed_on = 1'b0;
		key_cnt = 5;

		start_sent = bytes_sent;
		for (int p = 0; p < 3; p++) begin
			snd_idle = (p == 0) ? 27 : (p == 1) ? 60 : 0;
			rcv_idle = (p == 0) ? 60 : (p == 1) ? 27 : 0;
			if (p == 0) begin
				hold_asked++;
			end
			while (bytes_sent < start_sent + PHASE_BYTES * (p + 1)) begin
				build_key();
				key_cnt++;
				for (int i = 0; i < key_bytes.size(); i++) begin
					w.byte_in = key_bytes[i];
					w.last = (i == key_bytes.size() - 1);
					send_word(w);
				end
			end
			if (p < 2) begin
				key_valid <= 1'b0;
				while (parsed_q.size() != 0) begin
					@(posedge clk);
				end
				@(negedge clk);
			end
		end
		key_valid <= 1'b0;

		while (parsed_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (parsed_q.size() != 0) begin
			bad_words++;
		end

		$display("Ran %0d keys, %0d bytes (%0d parsed), %0d coordinate bytes checked.",
			key_cnt, bytes_sent, live_cnt, coord_cnt);
		$display("Verdicts: ok %0d, tag %0d, length %0d, size %0d, wide %0d, truncated %0d.",
			verdicts[0], verdicts[1], verdicts[2], verdicts[3], verdicts[4], verdicts[5]);
		if (bad_words == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d bad words.", bad_words);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
